// ===== sv/pkr_pkg.sv =====
// ----------------------------------------------------------------------------
// pkr_pkg: shared types and constants of the probe shuffle picker
// Field widths, register reset value and the sequencer state type.
// ----------------------------------------------------------------------------
package pkr_pkg;

   localparam int RND_W = 31;   // random number width
   localparam int CSR_W = 9;    // list size register width
   localparam int OUT_W = 8;    // chosen index width

   localparam logic [CSR_W-1:0] LIST_SIZE_RESET = 9'd1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_DIVIDE,
      ST_PROBE,
      ST_EMIT
   } pkr_state_type;

endpackage

// ===== sv/pkr_req_if.sv =====
// ----------------------------------------------------------------------------
// pkr_req_if: request channel of the probe shuffle picker
// Carries one random number and the run start flag per word.
// ----------------------------------------------------------------------------
interface pkr_req_if import pkr_pkg::*;;
   logic             valid;
   logic             ready;
   logic [RND_W-1:0] random_value;
   logic             start_run;

   modport source (output valid, output random_value, output start_run, input ready);
   modport sink   (input valid, input random_value, input start_run, output ready);
endinterface

// ===== sv/pkr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pkr_rsp_if: response channel of the probe shuffle picker
// Carries the chosen position and its completion and full flags per word.
// ----------------------------------------------------------------------------
interface pkr_rsp_if import pkr_pkg::*;;
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] chosen_index;
   logic             last_pick;
   logic             table_full;

   modport source (output valid, output chosen_index, output last_pick,
                   output table_full, input ready);
   modport sink   (input valid, input chosen_index, input last_pick,
                   input table_full, output ready);
endinterface

// ===== sv/pkr_mod_unit.sv =====
// ----------------------------------------------------------------------------
// pkr_mod_unit: iterative remainder unit
// Restoring remainder of the random number by the list size, one bit a cycle.
// Done rises after the last step and holds until the next start.
// ----------------------------------------------------------------------------
module pkr_mod_unit import pkr_pkg::*; #(
   parameter int SIZE_W = 9,
   parameter int IDX_W  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RND_W-1:0]  dividend,
   input  logic [SIZE_W-1:0] divisor,
   output logic              done,
   output logic [IDX_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(RND_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RND_W-1:0]  shift_ff, shift_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W:0]   trial;
   logic [SIZE_W:0]   diff;

   // Shift in the next dividend bit and subtract when the divisor fits.
   assign trial = {rem_ff, shift_ff[RND_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         cnt_in   = '0;
         shift_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[RND_W-2:0], 1'b0};
         cnt_in   = cnt_ff + CNT_W'(1);
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[SIZE_W-1:0];
         end else begin
            rem_in = trial[SIZE_W-1:0];
         end
         if (cnt_ff == CNT_W'(RND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = IDX_W'(rem_ff);

endmodule

// ===== sv/pkr_used_map.sv =====
// ----------------------------------------------------------------------------
// pkr_used_map: small RAM with a registered read
// One write port and one read port; holds the used-position map.
// ----------------------------------------------------------------------------
module pkr_used_map #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/probe_shuffle_picker.sv =====
// ----------------------------------------------------------------------------
// probe_shuffle_picker: random permutation builder with linear probing
// Reduces each random number modulo the list size, then walks forward with
// wrap-around to the first unused position, marks it and returns it.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake          word contents
//   --------  ----  -----------------  ---------------------------------------
//   req_chan  in    valid / ready      random_value, start_run
//   rsp_chan  out   valid / ready      chosen_index, last_pick, table_full
//   csr_*     in    csr_wr_en          csr_wr_data = list_size
//
// A word passes through the bit-serial remainder and its hand-off, then the
// probe (one used-map read issued per cycle, each checked when its registered
// read returns), then the emit state that loads the response. The probe stops
// at the second free position found, or after one full lap of the list. A run
// start first sweeps all LIST_MAX map entries to zero while the remainder
// runs. After reset the same sweep holds req_chan not ready. The response
// register holds its word while rsp_chan is stalled, and the next request is
// taken once the previous response is loaded.
// ----------------------------------------------------------------------------
module probe_shuffle_picker import pkr_pkg::*; #(
   parameter int LIST_MAX = 256
) (
   input  logic             clock,
   input  logic             reset,
   pkr_req_if.sink          req_chan,
   pkr_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   localparam int IDX_W  = $clog2(LIST_MAX);
   localparam int SIZE_W = $clog2(LIST_MAX + 1);

   // Configuration and per-word size snapshot
   logic [CSR_W-1:0]  list_size_ff, list_size_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] eff_size;

   // Sequencer
   pkr_state_type     state_ff, state_in;
   logic              req_accept;
   logic              div_done;
   logic              probe_load;
   logic              probe_en;
   logic              emit_fire;

   // Map sweep
   logic              clr_en;
   logic              clr_last;
   logic [IDX_W-1:0]  clr_ff, clr_in;

   // Probe walk: issue side
   logic [IDX_W-1:0]  rem;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [SIZE_W-1:0] tries_ff, tries_in;
   logic [SIZE_W-1:0] tries_nx;
   logic [SIZE_W-1:0] pos_nx;
   logic              issue;

   // Probe walk: check side
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_pos_ff, chk_pos_in;
   logic              chk_last_ff, chk_last_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  pick_ff, pick_in;
   logic              last_ff, last_in;
   logic              used_bit;
   logic              cur_free;
   logic              hit_second;
   logic              walk_end;

   // Used map write port
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic              ram_wr_data;

   // Response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_index_ff, rsp_index_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_full_ff, rsp_full_in;

   // -------------------------------------------------------------------------
   // Configuration: a size of zero acts as one, anything past LIST_MAX clamps.
   // -------------------------------------------------------------------------
   assign list_size_in = csr_wr_en ? csr_wr_data : list_size_ff;

   always_comb begin
      if (list_size_ff == '0) begin
         eff_size = SIZE_W'(1);
      end else if (32'(list_size_ff) > 32'(LIST_MAX)) begin
         eff_size = SIZE_W'(LIST_MAX);
      end else begin
         eff_size = SIZE_W'(list_size_ff);
      end
   end

   assign req_accept = req_chan.valid && req_chan.ready;
   assign size_in    = req_accept ? eff_size : size_ff;

   // -------------------------------------------------------------------------
   // Sequencer: next state
   // -------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               // a run start sweeps the map before the probe
               if (req_chan.start_run) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (walk_end) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // Sequencer: control outputs
   // -------------------------------------------------------------------------
   always_comb begin
      req_chan.ready = 1'b0;
      clr_en         = 1'b0;
      probe_load     = 1'b0;
      probe_en       = 1'b0;
      emit_fire      = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            clr_en = 1'b1;
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         ST_CLEAR: begin
            clr_en = 1'b1;
         end
         ST_DIVIDE: begin
            // the remainder holds once done, so a long sweep loses nothing
            probe_load = div_done;
         end
         ST_PROBE: begin
            probe_en = 1'b1;
         end
         ST_EMIT: begin
            // load only when the response register is free or draining
            emit_fire = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // Remainder unit: start position = random_value mod size. It starts at
   // acceptance and runs alongside any map sweep.
   // -------------------------------------------------------------------------
   pkr_mod_unit #(
      .SIZE_W (SIZE_W),
      .IDX_W  (IDX_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .dividend  (req_chan.random_value),
      .divisor   (eff_size),
      .done      (div_done),
      .remainder (rem)
   );

   // -------------------------------------------------------------------------
   // Map sweep: write zero to every entry, one per cycle, after reset and on a
   // run start. Wrap the counter back to zero on the last entry.
   // -------------------------------------------------------------------------
   assign clr_last = clr_en && (clr_ff == IDX_W'(LIST_MAX - 1));

   always_comb begin
      clr_in = clr_ff;
      if (clr_en) begin
         if (clr_last) begin
            clr_in = '0;
         end else begin
            clr_in = clr_ff + IDX_W'(1);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Used map: sweep writes zeros, an emitted pick writes a one. The read
   // address is the probe pointer; its bit comes back through the registered read.
   // -------------------------------------------------------------------------
   assign ram_wr_en   = clr_en || (emit_fire && found_ff);
   assign ram_wr_addr = clr_en ? clr_ff : pick_ff;
   assign ram_wr_data = !clr_en;

   pkr_used_map #(
      .WIDTH (1),
      .DEPTH (LIST_MAX)
   ) u_used (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (pos_ff),
      .rd_data (used_bit)
   );

   // -------------------------------------------------------------------------
   // Probe walk. Issue each position of the list once from the start point,
   // then check its bit in the next cycle. The first free one is the pick; a
   // second free one means the run is not complete, so stop there. A full lap
   // without any free one is table full.
   // -------------------------------------------------------------------------
   assign issue       = probe_en && (tries_ff != size_ff);
   assign tries_nx    = tries_ff + SIZE_W'(1);
   assign pos_nx      = SIZE_W'(pos_ff) + SIZE_W'(1);
   assign chk_vld_in  = issue;
   assign chk_pos_in  = pos_ff;
   assign chk_last_in = (tries_nx == size_ff);

   assign cur_free    = !used_bit;
   assign hit_second  = chk_vld_ff && cur_free && found_ff;
   assign walk_end    = hit_second || (chk_vld_ff && chk_last_ff);

   always_comb begin
      pos_in   = pos_ff;
      tries_in = tries_ff;
      found_in = found_ff;
      pick_in  = pick_ff;
      last_in  = last_ff;
      if (probe_load) begin
         pos_in   = rem;
         tries_in = '0;
         found_in = 1'b0;
      end else if (probe_en) begin
         if (issue) begin
            tries_in = tries_nx;
            // advance with wrap from size-1 to 0
            if (pos_nx == size_ff) begin
               pos_in = '0;
            end else begin
               pos_in = IDX_W'(pos_nx);
            end
         end
         if (chk_vld_ff && cur_free && !found_ff) begin
            found_in = 1'b1;
            pick_in  = chk_pos_ff;
         end
         if (walk_end) begin
            last_in = !hit_second;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response register
   // -------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_full_in  = rsp_full_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = found_ff ? OUT_W'(pick_ff) : '0;
         rsp_last_in  = found_ff && last_ff;
         rsp_full_in  = !found_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.chosen_index = rsp_index_ff;
   assign rsp_chan.last_pick    = rsp_last_ff;
   assign rsp_chan.table_full   = rsp_full_ff;

   // -------------------------------------------------------------------------
   // Registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         list_size_ff <= LIST_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         list_size_ff <= list_size_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
      end
      size_ff      <= size_in;
      pos_ff       <= pos_in;
      tries_ff     <= tries_in;
      chk_vld_ff   <= chk_vld_in;
      chk_pos_ff   <= chk_pos_in;
      chk_last_ff  <= chk_last_in;
      found_ff     <= found_in;
      pick_ff      <= pick_in;
      last_ff      <= last_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_full_ff  <= rsp_full_in;
   end

endmodule
